FILE: hw/rtl/pctd_pkg.sv
// Shared constants, types and control structs for the prime test / prime count block.
// Used by the channel interfaces, the divider, the sequencer and the top level.
`timescale 1ns / 1ps

package pctd_pkg;

  // Field widths
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 28;
  localparam int VALUE_BITS = 32;

  // Only the low min(VALUE_BITS, VAL_W) bits of the value take part
  localparam int MASK_W = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam logic [VAL_W-1:0] VALUE_MASK = (MASK_W >= VAL_W) ? {VAL_W{1'b1}} :
                                            VAL_W'((64'd1 << MASK_W) - 64'd1);

  // Root range and table sizes
  localparam int ROOT_W = VAL_W / 2;
  localparam int ROOT_N = 1 << ROOT_W;
  localparam int MUL_W  = ROOT_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(VAL_W);

  // Smallest prime and first odd trial divisor
  localparam int PRIME_TWO = 2;
  localparam int DIV_FIRST = 3;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] quot;
    logic [VAL_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

FILE: hw/rtl/pctd_ifs.sv
// Valid/ready channel interfaces: request beat (mode, value) and result beat
// (prime_flag, prime_count). Depends on pctd_pkg.
`timescale 1ns / 1ps

interface pctd_in_if import pctd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [VAL_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface pctd_out_if import pctd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             prime_flag;
  logic [CNT_W-1:0] prime_count;

  modport source (output valid, prime_flag, prime_count, input ready);
  modport sink   (input valid, prime_flag, prime_count, output ready);
endinterface

FILE: hw/rtl/prime_count_trial_division.sv
// Prime test and prime count block, top level. Depends on pctd_pkg, pctd_ifs,
// pctd_div and pctd_seq.
//
// Usage: each request beat on in_ch carries a value and a mode. One result beat on
// out_ch follows for each request: prime_flag tells whether the value is prime, and
// in count mode prime_count is the number of primes up to the value (0 in test mode).
// Work per item: the prime test tries odd divisors 3, 5, ... while the square stays
// within the value, one division per divisor. Count mode then fills the quotient
// table (one division for each k up to the square root), and each small-table
// update takes one division and each big-table update one or two. All divisions
// run on the shared divider.
// Throughput: one item at a time; in_ch.ready is high only while the sequencer idles.
// Reset (synchronous, active low) empties the result register and idles the
// sequencer; the count tables are not cleared, each item fills them before use.
// When the receiver stalls, the result waits in the output register and the block
// still takes and works on the next request beat.
`timescale 1ns / 1ps

module prime_count_trial_division import pctd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pctd_in_if.sink     in_ch,
  pctd_out_if.source  out_ch
);

  logic             seq_ready;
  logic             seq_take;
  logic             res_valid;
  logic             res_take;
  res_t             res;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             out_valid_r, out_valid_nxt;
  logic             out_flag_r, out_flag_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  assign in_ch.ready = seq_ready;
  assign seq_take    = in_ch.valid && seq_ready;

  pctd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (seq_take),
    .in_mode   (in_ch.mode),
    .in_value  (in_ch.value),
    .in_ready  (seq_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  pctd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;
    out_count_nxt = out_count_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_flag_nxt  = res.flag;
      out_count_nxt = res.count;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_flag_r  <= out_flag_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prime_flag  = out_flag_r;
  assign out_ch.prime_count = out_count_r;

endmodule

FILE: hw/rtl/pctd_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on pctd_pkg (div_req_t, div_rsp_t, widths).
`timescale 1ns / 1ps

module pctd_div import pctd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]     quo_r, quo_nxt;
  logic [VAL_W-1:0]     rem_r, rem_nxt;
  logic [VAL_W-1:0]     dvs_r, dvs_nxt;

  logic [VAL_W:0]       trial;
  logic [VAL_W:0]       diff;
  logic                 ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[VAL_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      quo_nxt = {quo_r[VAL_W-2:0], ge};
      rem_nxt = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(VAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

  // A new division is never asked for while one is in flight
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  // Done only closes a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  // Finished remainder is below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

endmodule

FILE: hw/rtl/pctd_seq.sv
// Sequencer: trial-division prime test and quotient-sieve prime count, driving the
// shared divider, one shared multiplier and the two count tables. Depends on pctd_pkg.
`timescale 1ns / 1ps

module pctd_seq import pctd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  logic             in_mode,
  input  logic [VAL_W-1:0] in_value,
  output logic             in_ready,
  output logic             res_valid,
  input  logic             res_take,
  output res_t             res,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp
);

  localparam int ST_W = 29;

  typedef enum logic [ST_W-1:0] {
    S_IDLE    = ST_W'(1) << 0,
    S_PT_CHK  = ST_W'(1) << 1,
    S_PT_SQ   = ST_W'(1) << 2,
    S_PT_CMP  = ST_W'(1) << 3,
    S_PT_DIV  = ST_W'(1) << 4,
    S_CNT_CHK = ST_W'(1) << 5,
    S_SQ_MUL  = ST_W'(1) << 6,
    S_SQ_CMP  = ST_W'(1) << 7,
    S_SI      = ST_W'(1) << 8,
    S_BI_DIV  = ST_W'(1) << 9,
    S_BI_WAIT = ST_W'(1) << 10,
    S_P_RD0   = ST_W'(1) << 11,
    S_P_RD1   = ST_W'(1) << 12,
    S_P_CHK   = ST_W'(1) << 13,
    S_P_SQ    = ST_W'(1) << 14,
    S_P_NEXT  = ST_W'(1) << 15,
    S_K_DIV   = ST_W'(1) << 16,
    S_K_DIVW  = ST_W'(1) << 17,
    S_K_PBIG  = ST_W'(1) << 18,
    S_K_PDIVW = ST_W'(1) << 19,
    S_K_PSML  = ST_W'(1) << 20,
    S_K_UPD   = ST_W'(1) << 21,
    S_V_CHK   = ST_W'(1) << 22,
    S_V_DIVW  = ST_W'(1) << 23,
    S_V_RD1   = ST_W'(1) << 24,
    S_V_UPD   = ST_W'(1) << 25,
    S_RES     = ST_W'(1) << 26,
    S_RES2    = ST_W'(1) << 27,
    S_FIN     = ST_W'(1) << 28
  } state_t;

  state_t state_r, state_nxt;

  logic [VAL_W-1:0]  n_r, n_nxt;
  logic              mode_r, mode_nxt;
  logic              flag_r, flag_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [MUL_W-1:0]  d_r, d_nxt;
  logic [ROOT_W-1:0] r_r, r_nxt;
  logic [MUL_W-1:0]  b_r, b_nxt;
  logic [ROOT_W-1:0] idx_r, idx_nxt;
  logic [MUL_W-1:0]  k_r, k_nxt;
  logic [ROOT_W-1:0] p_r, p_nxt;
  logic [ROOT_W-1:0] v_r, v_nxt;
  logic [ROOT_W-1:0] sp_r, sp_nxt;
  logic [ROOT_W-1:0] below_r, below_nxt;
  logic [VAL_W-1:0]  sq_r, sq_nxt;
  logic [VAL_W-1:0]  part_r, part_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // Shared multiplier operands
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [MUL_W-1:0]  trial_root;

  // Count tables: small_mem[v] counts up to v, big_mem[k] counts up to n/k
  logic [ROOT_W-1:0] small_mem [0:ROOT_N-1];
  logic [VAL_W-1:0]  big_mem   [0:ROOT_N-1];

  logic              sm_we;
  logic [ROOT_W-1:0] sm_waddr, sm_raddr;
  logic [ROOT_W-1:0] sm_wdata, sm_rdata_r;
  logic              bg_we;
  logic [ROOT_W-1:0] bg_waddr, bg_raddr;
  logic [VAL_W-1:0]  bg_wdata, bg_rdata_r;

  assign trial_root = {1'b0, r_r} + b_r;
  assign mul_p      = mul_a * mul_b;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    mode_nxt  = mode_r;
    flag_nxt  = flag_r;
    count_nxt = count_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    b_nxt     = b_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    v_nxt     = v_r;
    sp_nxt    = sp_r;
    below_nxt = below_r;
    sq_nxt    = sq_r;
    part_nxt  = part_r;
    prod_nxt  = prod_r;
    mul_a     = d_r;
    mul_b     = d_r;

    div_req.start    = 1'b0;
    div_req.dividend = n_r;
    div_req.divisor  = VAL_W'(k_r);

    sm_we    = 1'b0;
    sm_waddr = idx_r;
    sm_wdata = '0;
    sm_raddr = '0;
    bg_we    = 1'b0;
    bg_waddr = k_r[ROOT_W-1:0];
    bg_wdata = '0;
    bg_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          n_nxt     = in_value & VALUE_MASK;
          mode_nxt  = in_mode;
          state_nxt = S_PT_CHK;
        end
      end

      // Prime test: small values and even values first
      S_PT_CHK: begin
        state_nxt = S_CNT_CHK;
        if (n_r < VAL_W'(PRIME_TWO)) begin
          flag_nxt = 1'b0;
        end else if (n_r == VAL_W'(PRIME_TWO)) begin
          flag_nxt = 1'b1;
        end else if (!n_r[0]) begin
          flag_nxt = 1'b0;
        end else begin
          d_nxt     = MUL_W'(DIV_FIRST);
          state_nxt = S_PT_SQ;
        end
      end

      S_PT_SQ: begin
        mul_a     = d_r;
        mul_b     = d_r;
        prod_nxt  = mul_p;
        state_nxt = S_PT_CMP;
      end

      S_PT_CMP: begin
        if (prod_r > PROD_W'(n_r)) begin
          flag_nxt  = 1'b1;
          state_nxt = S_CNT_CHK;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = n_r;
          div_req.divisor  = VAL_W'(d_r);
          state_nxt        = S_PT_DIV;
        end
      end

      S_PT_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            flag_nxt  = 1'b0;
            state_nxt = S_CNT_CHK;
          end else begin
            d_nxt     = d_r + MUL_W'(PRIME_TWO);
            state_nxt = S_PT_SQ;
          end
        end
      end

      // Count only in count mode and from two up
      S_CNT_CHK: begin
        count_nxt = '0;
        if (mode_r && (n_r >= VAL_W'(PRIME_TWO))) begin
          r_nxt     = '0;
          b_nxt     = MUL_W'(1) << ROOT_W;
          state_nxt = S_SQ_MUL;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Integer square root, one bit per pass
      S_SQ_MUL: begin
        mul_a     = trial_root;
        mul_b     = trial_root;
        prod_nxt  = mul_p;
        state_nxt = S_SQ_CMP;
      end

      S_SQ_CMP: begin
        if (prod_r <= PROD_W'(n_r)) begin
          r_nxt = trial_root[ROOT_W-1:0];
        end
        b_nxt = b_r >> 1;
        if (b_r == MUL_W'(1)) begin
          idx_nxt   = '0;
          state_nxt = S_SI;
        end else begin
          state_nxt = S_SQ_MUL;
        end
      end

      // Fill small table with v-1 (0 for v = 0)
      S_SI: begin
        sm_we    = 1'b1;
        sm_waddr = idx_r;
        sm_wdata = (idx_r == '0) ? '0 : idx_r - 1'b1;
        if (idx_r == r_r) begin
          k_nxt     = MUL_W'(1);
          state_nxt = S_BI_DIV;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // Fill big table with n/k - 1
      S_BI_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = n_r;
        div_req.divisor  = VAL_W'(k_r);
        state_nxt        = S_BI_WAIT;
      end

      S_BI_WAIT: begin
        bg_waddr = k_r[ROOT_W-1:0];
        bg_wdata = div_rsp.quot - 1'b1;
        if (div_rsp.done) begin
          bg_we = 1'b1;
          if (k_r[ROOT_W-1:0] == r_r) begin
            if (r_r < ROOT_W'(PRIME_TWO)) begin
              state_nxt = S_RES;
            end else begin
              p_nxt     = ROOT_W'(PRIME_TWO);
              state_nxt = S_P_RD0;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_BI_DIV;
          end
        end
      end

      // Sieve pass for p: skip unless p is prime
      S_P_RD0: begin
        sm_raddr  = p_r;
        state_nxt = S_P_RD1;
      end

      S_P_RD1: begin
        sm_raddr  = p_r - 1'b1;
        sp_nxt    = sm_rdata_r;
        state_nxt = S_P_CHK;
      end

      S_P_CHK: begin
        mul_a    = {1'b0, p_r};
        mul_b    = {1'b0, p_r};
        prod_nxt = mul_p;
        if (sp_r == sm_rdata_r) begin
          state_nxt = S_P_NEXT;
        end else begin
          below_nxt = sm_rdata_r;
          state_nxt = S_P_SQ;
        end
      end

      S_P_SQ: begin
        sq_nxt    = prod_r[VAL_W-1:0];
        k_nxt     = MUL_W'(1);
        state_nxt = S_K_DIV;
      end

      // Big table update for k while k <= r and n/k >= p*p
      S_K_DIV: begin
        mul_a    = k_r;
        mul_b    = {1'b0, p_r};
        prod_nxt = mul_p;
        if (k_r > {1'b0, r_r}) begin
          v_nxt     = r_r;
          state_nxt = S_V_CHK;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = n_r;
          div_req.divisor  = VAL_W'(k_r);
          state_nxt        = S_K_DIVW;
        end
      end

      S_K_DIVW: begin
        bg_raddr = prod_r[ROOT_W-1:0];
        if (div_rsp.done) begin
          if (div_rsp.quot < sq_r) begin
            v_nxt     = r_r;
            state_nxt = S_V_CHK;
          end else if (prod_r <= PROD_W'(r_r)) begin
            state_nxt = S_K_PBIG;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = n_r;
            div_req.divisor  = prod_r[VAL_W-1:0];
            state_nxt        = S_K_PDIVW;
          end
        end
      end

      S_K_PBIG: begin
        part_nxt  = bg_rdata_r;
        bg_raddr  = k_r[ROOT_W-1:0];
        state_nxt = S_K_UPD;
      end

      S_K_PDIVW: begin
        sm_raddr = div_rsp.quot[ROOT_W-1:0];
        if (div_rsp.done) begin
          state_nxt = S_K_PSML;
        end
      end

      S_K_PSML: begin
        part_nxt  = VAL_W'(sm_rdata_r);
        bg_raddr  = k_r[ROOT_W-1:0];
        state_nxt = S_K_UPD;
      end

      S_K_UPD: begin
        bg_we     = 1'b1;
        bg_waddr  = k_r[ROOT_W-1:0];
        bg_wdata  = bg_rdata_r - (part_r - VAL_W'(below_r));
        k_nxt     = k_r + 1'b1;
        state_nxt = S_K_DIV;
      end

      // Small table update for v from r down to p*p
      S_V_CHK: begin
        if (VAL_W'(v_r) < sq_r) begin
          state_nxt = S_P_NEXT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = VAL_W'(v_r);
          div_req.divisor  = VAL_W'(p_r);
          state_nxt        = S_V_DIVW;
        end
      end

      S_V_DIVW: begin
        sm_raddr = div_rsp.quot[ROOT_W-1:0];
        if (div_rsp.done) begin
          state_nxt = S_V_RD1;
        end
      end

      S_V_RD1: begin
        part_nxt  = VAL_W'(sm_rdata_r);
        sm_raddr  = v_r;
        state_nxt = S_V_UPD;
      end

      S_V_UPD: begin
        sm_we     = 1'b1;
        sm_waddr  = v_r;
        sm_wdata  = sm_rdata_r - (part_r[ROOT_W-1:0] - below_r);
        v_nxt     = v_r - 1'b1;
        state_nxt = S_V_CHK;
      end

      S_P_NEXT: begin
        if (p_r == r_r) begin
          state_nxt = S_RES;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_P_RD0;
        end
      end

      // Count is big_mem[1]
      S_RES: begin
        bg_raddr  = ROOT_W'(1);
        state_nxt = S_RES2;
      end

      S_RES2: begin
        count_nxt = bg_rdata_r[CNT_W-1:0];
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    mode_r  <= mode_nxt;
    flag_r  <= flag_nxt;
    count_r <= count_nxt;
    d_r     <= d_nxt;
    r_r     <= r_nxt;
    b_r     <= b_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    v_r     <= v_nxt;
    sp_r    <= sp_nxt;
    below_r <= below_nxt;
    sq_r    <= sq_nxt;
    part_r  <= part_nxt;
    prod_r  <= prod_nxt;
  end

  // Count tables, registered read
  always_ff @(posedge clk) begin
    if (sm_we) begin
      small_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata_r <= small_mem[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      big_mem[bg_waddr] <= bg_wdata;
    end
    bg_rdata_r <= big_mem[bg_raddr];
  end

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_FIN);
  assign res.flag   = flag_r;
  assign res.count  = count_r;

  // A divider result only lands in a state that waits for one
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_PT_DIV || state_r == S_BI_WAIT ||
                      state_r == S_K_DIVW || state_r == S_K_PDIVW ||
                      state_r == S_V_DIVW))
    else $error("divider result with no waiting state");

  // The divider is only started while it is free
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Big table update always follows a fetch of its partial term
  a_k_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K_UPD) |-> $past(state_r == S_K_PBIG || state_r == S_K_PSML))
    else $error("big table update without partial term");

  // Small table sweep stays inside the root range
  a_v_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_V_CHK) |-> (v_r <= r_r))
    else $error("small table index above root");

endmodule

FILE: test/tb_prime_count_trial_division.sv
// Self-checking bench for prime_count_trial_division: drives request beats, predicts
// prime_flag and prime_count and checks every result beat. Depends on pctd_pkg, pctd_ifs
// and the RTL of the block.
`timescale 1ns / 1ps

module tb_prime_count_trial_division;
  import pctd_pkg::*;

  // Count requests stay within the range of the prime table below
  localparam int COUNT_LIM    = 1 << 20;
  localparam int N_DIRECTED   = 24;
  localparam int N_RANDOM     = 80;
  localparam int STALL_LO     = 40;
  localparam int STALL_HI     = 52;
  localparam int HOLD_CYCLES  = 1000;
  localparam int PAUSE_AT     = 75;
  localparam int DRAIN_CYCLES = 2000;
  localparam int LIMIT_CYCLES = 50_000_000;

  // Expected result beats and the prime tables behind them
  class prime_scoreboard;
    res_t        pending[$];
    int          errors;
    int          beats_in;
    int unsigned upto[];

    // primes <= n for every n the count requests can reach
    function new();
      bit          composite[];
      int unsigned run;
      composite = new[COUNT_LIM + 1];
      upto      = new[COUNT_LIM + 1];
      run       = 0;
      errors    = 0;
      beats_in  = 0;
      for (int n = 0; n <= COUNT_LIM; n++) begin
        if (n >= 2 && !composite[n]) begin
          run++;
          for (longint k = longint'(n) * n; k <= COUNT_LIM; k += n) composite[k] = 1'b1;
        end
        upto[n] = run;
      end
    endfunction

    // trial division: 2 is prime, other evens are not, odd divisors from 3
    function bit trial_prime(logic [VAL_W-1:0] v);
      longint unsigned d;
      if (v < 2) return 1'b0;
      if (v == 2) return 1'b1;
      if (!v[0]) return 1'b0;
      for (d = 3; d * d <= v; d += 2)
        if (v % d == 0) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(logic m, logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] val;
      res_t             want;
      val        = v & VALUE_MASK;
      want.flag  = trial_prime(val);
      want.count = m ? CNT_W'(upto[val]) : '0;
      pending.push_back(want);
      beats_in++;
    endfunction

    function void check_result(logic flag, logic [CNT_W-1:0] count);
      res_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat: prime_flag %0b prime_count %0d", flag, count);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (flag !== want.flag) begin
        $error("prime_flag: expected %0b, got %0b", want.flag, flag);
        errors++;
      end
      if (count !== want.count) begin
        $error("prime_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  bit              calm;
  int unsigned     cycles = 0;
  prime_scoreboard sb = new();

  pctd_in_if  in_if ();
  pctd_out_if out_if ();

  prime_count_trial_division u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed beats: {mode, value}
  logic [VAL_W:0] directed [N_DIRECTED] = '{
    {1'b0, 32'd0}, {1'b1, 32'd0}, {1'b0, 32'd1}, {1'b1, 32'd1},
    {1'b0, 32'd2}, {1'b1, 32'd2}, {1'b0, 32'd3}, {1'b1, 32'd3},
    {1'b0, 32'd4}, {1'b1, 32'd4}, {1'b1, 32'd9}, {1'b0, 32'd25},
    {1'b0, 32'd97}, {1'b1, 32'd100}, {1'b1, 32'd1000}, {1'b0, 32'hFFFF_FFFF},
    {1'b0, 32'hFFFF_FFFE}, {1'b0, 32'h8000_0000}, {1'b0, 32'd65537},
    {1'b0, 32'd16777213}, {1'b1, 32'd65535}, {1'b1, 32'(COUNT_LIM)},
    {1'b1, 32'(COUNT_LIM - 1)}, {1'b1, 32'd7919}
  };

  // One request beat; called after an accept edge, returns on the next accept edge
  task automatic send_beat(input logic m, input logic [VAL_W-1:0] v);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(m, v);
  endtask

  // Result sink: random back-pressure, one long hold-off while requests keep coming
  initial begin
    bit held;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.beats_in >= N_DIRECTED + STALL_LO + 1) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_if.ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // Check every accepted result beat
  always @(posedge clk)
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.prime_flag, out_if.prime_count);

  // Stimulus
  initial begin
    logic             m;
    logic [VAL_W-1:0] v;
    int               sel;
    int               p;
    rst_n       = 1'b0;
    calm        = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode  = 1'b0;
    in_if.value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_beat(directed[k][VAL_W], directed[k][VAL_W-1:0]);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 15 && i < 35);
      // hold the sender back until every result is home
      if (i == PAUSE_AT) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end
      sel = $urandom_range(99);
      m   = 1'($urandom_range(1));
      if (i >= STALL_LO && i < STALL_HI) begin
        // tiny items so the block fills up behind the stalled sink
        v = $urandom_range(31);
      end else if (m) begin
        v = (sel < 85) ? $urandom_range(4095) : $urandom_range(65535);
      end else if (sel < 50) begin
        v = $urandom & ((32'd1 << $urandom_range(16, 1)) - 32'd1);
      end else if (sel < 75) begin
        v = $urandom_range(COUNT_LIM);
      end else begin
        // full width, but with a small factor so the trial loop ends early
        v = $urandom;
        case ($urandom_range(3))
          0:       p = 2;
          1:       p = 3;
          2:       p = 5;
          default: p = 7;
        endcase
        v = v - v % p;
      end
      send_beat(m, v);
    end
    calm = 1'b0;

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
